// ===== sv/at_command_loopback_responder_assert.svh =====
// Assertion macros shared by the AT responder modules.
// Each expects a clock named clk and a synchronous reset named rst in scope.
`ifndef AT_COMMAND_LOOPBACK_RESPONDER_ASSERT_SVH
`define AT_COMMAND_LOOPBACK_RESPONDER_ASSERT_SVH

// Same-cycle implication
`define ATCLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ATCLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/atclr_pkg.sv =====
// Shared types, constants and the response table for the AT responder.
// No dependencies.
package atclr_pkg;

  // FIFO geometry
  localparam int FIFO_DEPTH = 1024;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Read length handling
  localparam int MAX_READ = 64;
  localparam int LEN_W    = 7;
  localparam int CMP_W    = (FIFO_CW > LEN_W) ? FIFO_CW : LEN_W;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Matcher states
  localparam logic [1:0] MS_IDLE  = 2'd0;
  localparam logic [1:0] MS_GOT_A = 2'd1;
  localparam logic [1:0] MS_GOT_T = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_UT  = 8'h54;
  localparam logic [7:0] CH_LT  = 8'h74;
  localparam logic [7:0] CH_UD  = 8'h44;
  localparam logic [7:0] CH_LD  = 8'h64;
  localparam logic [7:0] CH_UC  = 8'h43;
  localparam logic [7:0] CH_UO  = 8'h4F;
  localparam logic [7:0] CH_UN  = 8'h4E;
  localparam logic [7:0] CH_UE  = 8'h45;
  localparam logic [7:0] CH_UK  = 8'h4B;

  // Response sequences
  localparam int         RSP_IDX_W       = 4;
  localparam logic [3:0] RSP_CONNECT_LEN = 4'd11;
  localparam logic [3:0] RSP_OK_LEN      = 4'd6;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic [6:0] read_length;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       connected;
    logic       carrier_changed;
  } out_res_t;

  // Controller to datapath
  typedef struct packed {
    logic                 wr_byte;   // write request accepted
    logic                 wr_resp;   // push one response character
    logic                 resp_conn;
    logic [RSP_IDX_W-1:0] resp_idx;
    logic                 rd_issue;  // read FIFO head, advance
    logic                 out_load;  // capture RAM data into output
    logic                 out_last;
    logic                 out_empty; // load the empty-read result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             is_read;
    logic [LEN_W-1:0] take;      // bytes this read will return
    logic             resp_req;  // this write ends a command line
    logic             resp_conn; // ... and it is a connect command
    logic             out_free;  // output register free next cycle
  } sts_t;

  // Response character lookup
  function automatic logic [7:0] rsp_byte(input logic conn,
                                          input logic [RSP_IDX_W-1:0] idx);
    logic [7:0] b;
    b = CH_NUL;
    if (conn) begin
      unique case (idx)
        4'd0:    b = CH_CR;
        4'd1:    b = CH_LF;
        4'd2:    b = CH_UC;
        4'd3:    b = CH_UO;
        4'd4:    b = CH_UN;
        4'd5:    b = CH_UN;
        4'd6:    b = CH_UE;
        4'd7:    b = CH_UC;
        4'd8:    b = CH_UT;
        4'd9:    b = CH_CR;
        4'd10:   b = CH_LF;
        default: b = CH_NUL;
      endcase
    end else begin
      unique case (idx)
        4'd0:    b = CH_CR;
        4'd1:    b = CH_LF;
        4'd2:    b = CH_UO;
        4'd3:    b = CH_UK;
        4'd4:    b = CH_CR;
        4'd5:    b = CH_LF;
        default: b = CH_NUL;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== sv/atclr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module atclr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/atclr_ctrl.sv =====
// Sequencer for the AT responder: request intake, response push, FIFO drain.
// Depends on atclr_pkg and the assertion macro header.
`include "at_command_loopback_responder_assert.svh"

module atclr_ctrl
  import atclr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RESP     = 3'd1;
  localparam logic [2:0] S_RD_ADDR  = 3'd2;
  localparam logic [2:0] S_RD_DATA  = 3'd3;
  localparam logic [2:0] S_RD_EMPTY = 3'd4;

  logic [2:0]           state, state_next;
  logic [RSP_IDX_W-1:0] resp_idx, resp_idx_next;
  logic                 resp_conn, resp_conn_next;
  logic [LEN_W-1:0]     remaining, remaining_next;
  logic                 accept;
  logic [RSP_IDX_W-1:0] resp_end;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign resp_end  = resp_conn ? (RSP_CONNECT_LEN - 4'd1) : (RSP_OK_LEN - 4'd1);

  // Next state and commands
  always_comb begin
    state_next     = state;
    resp_idx_next  = resp_idx;
    resp_conn_next = resp_conn;
    remaining_next = remaining;
    cmd            = '0;
    cmd.resp_conn  = resp_conn;
    cmd.resp_idx   = resp_idx;
    cmd.out_last   = (remaining == LEN_W'(1));
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.is_read) begin
            remaining_next = sts.take;
            state_next     = (sts.take == '0) ? S_RD_EMPTY : S_RD_ADDR;
          end else begin
            cmd.wr_byte = 1'b1;
            if (sts.resp_req) begin
              resp_conn_next = sts.resp_conn;
              resp_idx_next  = '0;
              state_next     = S_RESP;
            end
          end
        end
      end
      S_RESP: begin
        cmd.wr_resp   = 1'b1;
        resp_idx_next = resp_idx + 1'b1;
        if (resp_idx == resp_end) begin
          state_next = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        if (sts.out_free) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        cmd.out_load   = 1'b1;
        remaining_next = remaining - 1'b1;
        state_next     = (remaining == LEN_W'(1)) ? S_IDLE : S_RD_ADDR;
      end
      S_RD_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_empty = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resp_idx  <= '0;
      resp_conn <= 1'b0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      resp_idx  <= resp_idx_next;
      resp_conn <= resp_conn_next;
      remaining <= remaining_next;
    end
  end

  `ATCLR_ASSERT_NEXT(a_issue_then_load, cmd.rd_issue, cmd.out_load, "read data not captured")
  `ATCLR_ASSERT_NOW(a_resp_idx_range, state == S_RESP, resp_idx <= resp_end, "response overrun")
  `ATCLR_ASSERT_NOW(a_drain_nonzero, state == S_RD_ADDR || state == S_RD_DATA, remaining != '0, "drain with nothing left")

endmodule

// ===== sv/atclr_dp.sv =====
// Datapath for the AT responder: command matcher, receive FIFO, output register.
// Depends on atclr_pkg, atclr_ram and the assertion macro header.
`include "at_command_loopback_responder_assert.svh"

module atclr_dp
  import atclr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  in_req_t  req_data,
  input  cmd_t     cmd,
  output sts_t     sts,
  output logic     res_valid,
  input  logic     res_stall,
  output out_res_t res_data
);

  // Matcher and carrier state
  logic [1:0] match_state;
  logic       connect_pending, skip_check;
  logic       carrier_on, carrier_event;
  logic [1:0] match_state_next;
  logic       connect_pending_next, skip_check_next;

  // FIFO state
  logic [FIFO_AW-1:0] head, tail;
  logic [FIFO_CW-1:0] count;
  logic               push, push_ok;
  logic [7:0]         push_byte;
  logic [7:0]         ram_rd_data;

  // Byte decode
  logic [7:0]       c;
  logic             nz, is_a, is_t, is_d, is_cr, wr_nz;
  logic [LEN_W-1:0] len_sat;
  logic [CMP_W-1:0] cnt_ext, len_ext;

  assign c     = req_data.data_byte;
  assign nz    = (c != CH_NUL);
  assign is_a  = (c == CH_UA) || (c == CH_LA);
  assign is_t  = (c == CH_UT) || (c == CH_LT);
  assign is_d  = (c == CH_UD) || (c == CH_LD);
  assign is_cr = (c == CH_CR);
  assign wr_nz = cmd.wr_byte && nz;

  // Matcher next state
  always_comb begin
    match_state_next     = match_state;
    connect_pending_next = connect_pending;
    skip_check_next      = skip_check;
    unique case (match_state)
      MS_IDLE: begin
        if (is_a) begin
          match_state_next     = MS_GOT_A;
          connect_pending_next = 1'b0;
          skip_check_next      = 1'b0;
        end
      end
      MS_GOT_A: begin
        if (is_t) begin
          match_state_next = MS_GOT_T;
        end else if (is_cr) begin
          match_state_next = MS_IDLE;
        end
      end
      MS_GOT_T: begin
        if (!skip_check && (is_a || is_d)) begin
          connect_pending_next = 1'b1;
        end
        skip_check_next = 1'b1;
        if (is_cr) begin
          match_state_next = MS_IDLE;
        end
      end
      default: begin
        match_state_next = match_state;
      end
    endcase
  end

  // Read length clamp and bytes to take
  assign len_sat = (req_data.read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ)
                                                              : req_data.read_length;
  assign cnt_ext = CMP_W'(count);
  assign len_ext = CMP_W'(len_sat);

  always_comb begin
    sts           = '0;
    sts.is_read   = (req_data.req_type == REQ_READ);
    sts.take      = (cnt_ext < len_ext) ? LEN_W'(cnt_ext) : len_sat;
    sts.resp_req  = nz && (match_state == MS_GOT_T) && is_cr;
    sts.resp_conn = connect_pending_next;
    sts.out_free  = !res_valid || !res_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_state     <= MS_IDLE;
      connect_pending <= 1'b0;
      skip_check      <= 1'b0;
      carrier_on      <= 1'b0;
      carrier_event   <= 1'b0;
    end else if (wr_nz) begin
      match_state     <= match_state_next;
      connect_pending <= connect_pending_next;
      skip_check      <= skip_check_next;
      if (sts.resp_req && connect_pending_next) begin
        carrier_on    <= 1'b1;
        carrier_event <= 1'b1;
      end
    end
  end

  // FIFO push: echoed byte or response character, dropped when full
  assign push      = wr_nz || cmd.wr_resp;
  assign push_byte = cmd.wr_resp ? rsp_byte(cmd.resp_conn, cmd.resp_idx) : c;
  assign push_ok   = push && (count < FIFO_CW'(FIFO_DEPTH));

  atclr_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (tail),
    .wr_data (push_byte),
    .rd_addr (head),
    .rd_data (ram_rd_data)
  );

  // Pointers and fill count; pushes and pops never coincide
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (push_ok) begin
      tail  <= (tail == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
      count <= count + 1'b1;
    end else if (cmd.rd_issue) begin
      head  <= (head == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
      count <= count - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_empty) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_data <= '{out_byte: ram_rd_data, byte_valid: 1'b1, last_byte: cmd.out_last,
                    connected: carrier_on, carrier_changed: carrier_event};
    end else if (cmd.out_empty) begin
      res_data <= '{out_byte: CH_NUL, byte_valid: 1'b0, last_byte: 1'b1,
                    connected: carrier_on, carrier_changed: carrier_event};
    end
  end

  `ATCLR_ASSERT_NOW(a_count_bound, 1'b1, count <= FIFO_CW'(FIFO_DEPTH), "fill count above depth")
  `ATCLR_ASSERT_NOW(a_empty_ptrs, count == '0, head == tail, "empty FIFO with split pointers")
  `ATCLR_ASSERT_NOW(a_load_free, cmd.out_load, !res_valid, "output overwritten before taken")

endmodule

// ===== sv/at_command_loopback_responder.sv =====
// AT command loopback responder: echoes host bytes into a 1024-byte receive FIFO.
// Write request: a command-ending CR then pushes OK (6 bytes) or CONNECT (11 bytes).
// Read request: per byte, an address state (waits for a free output) and a data state,
// set by the registered FIFO RAM read; an empty read gives one result; requests wait.
// Synchronous active-high reset empties the FIFO and clears matcher and carrier flags.
// Depends on atclr_pkg, atclr_ctrl and atclr_dp.
module at_command_loopback_responder
  import atclr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  in_req_t  req_data,
  output logic     res_valid,
  input  logic     res_stall,
  output out_res_t res_data
);

  cmd_t cmd;
  sts_t sts;

  atclr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  atclr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

// ===== bench/modem_echo_checker.sv =====
`timescale 1ns / 100ps
// Checker for the AT command loopback responder: mirrors the receive FIFO and command
// matcher, predicts the bytes each read returns and compares them. Depends on atclr_pkg.
module modem_echo_checker
  import atclr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  in_req_t  req_data,
  input  logic     res_valid,
  input  logic     res_stall,
  input  out_res_t res_data,
  output int       fail_count,
  output int       bytes_owed
);

  // Mirror of the receive FIFO
  logic [7:0]         rx_ring [FIFO_DEPTH];
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr;
  int                 rx_fill;

  // Mirror of the command matcher and carrier flags
  logic [1:0] line_state;
  logic       dial_cmd;
  logic       cmd_checked;
  logic       carrier;
  logic       carrier_flag;

  // Read results still to come, oldest first
  out_res_t awaited [$];

  task automatic report(input string what);
    if (fail_count < 50) $display("[%0t] ERROR %s", $time, what);
    fail_count++;
  endtask

  // A byte pushed while the FIFO is full is simply lost
  task automatic push_rx(input logic [7:0] b);
    if (rx_fill < FIFO_DEPTH) begin
      rx_ring[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      rx_fill++;
    end
  endtask

  task automatic push_reply(input logic conn);
    push_rx(CH_CR);
    push_rx(CH_LF);
    if (conn) begin
      push_rx(CH_UC);
      push_rx(CH_UO);
      push_rx(CH_UN);
      push_rx(CH_UN);
      push_rx(CH_UE);
      push_rx(CH_UC);
      push_rx(CH_UT);
    end else begin
      push_rx(CH_UO);
      push_rx(CH_UK);
    end
    push_rx(CH_CR);
    push_rx(CH_LF);
  endtask

  // Host write: echo, then step the matcher
  task automatic host_char(input logic [7:0] c);
    if (c != CH_NUL) begin
      push_rx(c);
      case (line_state)
        MS_IDLE: begin
          if (c == CH_UA || c == CH_LA) begin
            line_state  = MS_GOT_A;
            dial_cmd    = 1'b0;
            cmd_checked = 1'b0;
          end
        end
        MS_GOT_A: begin
          if (c == CH_UT || c == CH_LT) line_state = MS_GOT_T;
          else if (c == CH_CR) line_state = MS_IDLE;
        end
        MS_GOT_T: begin
          // only the first character after AT decides connect (answer or dial) vs plain
          if (!cmd_checked && (c == CH_UA || c == CH_LA || c == CH_UD || c == CH_LD))
            dial_cmd = 1'b1;
          cmd_checked = 1'b1;
          if (c == CH_CR) begin
            line_state = MS_IDLE;
            push_reply(dial_cmd);
            if (dial_cmd) begin
              carrier      = 1'b1;
              carrier_flag = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // Host read: drain up to the saturated length, or one empty result
  task automatic host_read(input logic [6:0] len);
    int       want;
    int       n;
    out_res_t r;
    want = (int'(len) > MAX_READ) ? MAX_READ : int'(len);
    r.connected       = carrier;
    r.carrier_changed = carrier_flag;
    if (rx_fill == 0 || want == 0) begin
      r.out_byte   = CH_NUL;
      r.byte_valid = 1'b0;
      r.last_byte  = 1'b1;
      awaited.push_back(r);
    end else begin
      n = (want < rx_fill) ? want : rx_fill;
      for (int i = 0; i < n; i++) begin
        r.out_byte   = rx_ring[rd_ptr];
        r.byte_valid = 1'b1;
        r.last_byte  = (i + 1 == n);
        rd_ptr       = rd_ptr + 1'b1;
        rx_fill--;
        awaited.push_back(r);
      end
    end
  endtask

  // Results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    out_res_t want;
    if (rst) begin
      rd_ptr       = '0;
      wr_ptr       = '0;
      rx_fill      = 0;
      line_state   = MS_IDLE;
      dial_cmd     = 1'b0;
      cmd_checked  = 1'b0;
      carrier      = 1'b0;
      carrier_flag = 1'b0;
      fail_count   = 0;
      awaited.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (awaited.size() == 0) begin
          report($sformatf("result with none outstanding: %h", res_data));
        end else begin
          want = awaited.pop_front();
          if (res_data.out_byte !== want.out_byte || res_data.byte_valid !== want.byte_valid ||
              res_data.last_byte !== want.last_byte || res_data.connected !== want.connected ||
              res_data.carrier_changed !== want.carrier_changed)
            report($sformatf({"read result byte %h valid %b last %b conn %b chg %b, ",
                              "wanted byte %h valid %b last %b conn %b chg %b"},
                             res_data.out_byte, res_data.byte_valid, res_data.last_byte,
                             res_data.connected, res_data.carrier_changed,
                             want.out_byte, want.byte_valid, want.last_byte,
                             want.connected, want.carrier_changed));
        end
      end
      if (req_valid && !req_stall) begin
        if (req_data.req_type == REQ_READ) host_read(req_data.read_length);
        else host_char(req_data.data_byte);
      end
    end
    bytes_owed = awaited.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the AT responder bench: clock, reset, request stimulus, result stalls and verdict.
// Depends on atclr_pkg, at_command_loopback_responder and modem_echo_checker.
module testbench;
  import atclr_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_REQS  = 256;

  logic     clk;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  in_req_t  req_data  = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  out_res_t res_data;

  int errors;
  int owed;
  int cycle_count = 0;
  int stall_left  = 0;
  int reqs        = 0;
  bit calm        = 1'b0;

  at_command_loopback_responder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  modem_echo_checker echo_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .fail_count (errors),
    .bytes_owed (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result-side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      res_stall <= 1'b0;
      if (!calm && $urandom_range(0, 5) == 0)
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send(input in_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_data  <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    reqs++;
  endtask

  task automatic put_char(input logic [7:0] b);
    in_req_t r;
    r.req_type    = REQ_WRITE;
    r.data_byte   = b;
    r.read_length = 7'($urandom);
    send(r);
  endtask

  task automatic ask(input logic [6:0] len);
    in_req_t r;
    r.req_type    = REQ_READ;
    r.data_byte   = 8'($urandom);
    r.read_length = len;
    send(r);
  endtask

  initial begin
    int pick;
    int stop_at;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, NUL, plain AT, CR after A, dial, odd read lengths
    ask(7'd5);
    put_char(CH_NUL);
    put_char(CH_UA);
    put_char(CH_UT);
    put_char(CH_CR);
    ask(7'(MAX_READ));
    put_char(CH_LA);
    put_char(CH_CR);
    put_char(CH_LA);
    put_char(CH_LT);
    put_char(CH_LD);
    put_char(8'hFF);
    put_char(CH_CR);
    ask(7'd0);
    ask(7'd1);
    ask(7'd127);
    put_char(8'h80);
    put_char(CH_UT);
    put_char(CH_UA);
    put_char(CH_UT);
    put_char(CH_UA);
    put_char(CH_CR);
    ask(7'(MAX_READ));

    // Random: mostly well-formed command lines, reads, some noise and broken lines
    stop_at = reqs + RANDOM_REQS;
    while (reqs < stop_at) begin
      calm = ((reqs / 32) % 4) == 3;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: ask(7'($urandom_range(1, MAX_READ)));
          6, 7:             ask(7'($urandom_range(1, 8)));
          default:          ask(7'($urandom_range(0, 127)));
        endcase
      end else if (pick < 75) begin
        put_char($urandom_range(0, 1) ? CH_UA : CH_LA);
        put_char($urandom_range(0, 1) ? CH_UT : CH_LT);
        case ($urandom_range(0, 3))
          0: put_char($urandom_range(0, 1) ? CH_UD : CH_LD);
          1: put_char($urandom_range(0, 1) ? CH_UA : CH_LA);
          2: put_char(8'($urandom_range(32, 126)));
          default: ;
        endcase
        repeat ($urandom_range(0, 4)) put_char(8'($urandom_range(32, 126)));
        put_char(CH_CR);
      end else if (pick < 90) begin
        put_char(($urandom_range(0, 4) == 0) ? CH_NUL : 8'($urandom));
      end else begin
        // broken lines: A then CR, AT cut short, A then junk
        case ($urandom_range(0, 2))
          0: begin
            put_char(CH_UA);
            put_char(CH_CR);
          end
          1: begin
            put_char(CH_LA);
            put_char(CH_UT);
          end
          default: begin
            put_char(CH_UA);
            put_char(8'($urandom_range(32, 126)));
          end
        endcase
      end
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // Let every outstanding result arrive, then a short quiet spell
    do @(posedge clk); while (owed != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && owed == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
